>>> sv/sphere_collision_resolver_unit_macros.svh
// Assertion macros for the sphere collision resolver.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef SPHERE_COLLISION_RESOLVER_UNIT_MACROS_SVH
`define SPHERE_COLLISION_RESOLVER_UNIT_MACROS_SVH

// Check a same-cycle implication, off while in reset
`define SCR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication in the next cycle, off while in reset
`define SCR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/scr_pkg.sv
// Shared types and codes for the sphere collision resolver.
// No dependencies; used by scr_iter_alu and the top level.
package scr_pkg;

    // Operation codes carried in the input item's tuser
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_RESOLVE = 2'd2;

    // Operations of the shared iterative unit
    typedef enum logic [1:0] {
        ALU_MUL  = 2'd0,
        ALU_DIV  = 2'd1,
        ALU_SQRT = 2'd2
    } t_alu_op;

    typedef struct packed {
        logic        start;
        t_alu_op     op;
        logic [63:0] a;
        logic [63:0] b;
    } t_alu_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] result;
    } t_alu_rsp;

    // One body record as held in the store
    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [30:0]      mass;
        logic [30:0]      inv;
        logic [30:0]      radius;
        logic [15:0]      rest;
    } t_body;

endpackage

>>> sv/scr_iter_alu.sv
// Iterative unsigned 64-bit multiply, divide and square root unit.
// Depends on scr_pkg for its request and response types.
module scr_iter_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  scr_pkg::t_alu_req i_req,
    output scr_pkg::t_alu_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    scr_pkg::t_alu_op  r_op;
    logic [5:0]        r_cnt;
    logic [63:0]       r_x;
    logic [63:0]       r_y;
    logic [63:0]       r_acc;
    logic [63:0]       r_res;

    // Restoring divide step: remainder in r_acc, dividend/quotient in r_x
    logic [64:0] w_rem2;
    logic        w_dge;
    logic [64:0] w_rem_n;
    // Square root step: value in r_x, bit in r_y, root in r_acc
    logic [63:0] w_t;
    logic        w_sge;
    logic [63:0] w_root_n;

    always_comb begin
        w_rem2   = {r_acc, r_x[63]};
        w_dge    = w_rem2 >= {1'b0, r_y};
        w_rem_n  = w_dge ? (w_rem2 - {1'b0, r_y}) : w_rem2;
        w_t      = r_acc + r_y;
        w_sge    = r_x >= w_t;
        w_root_n = w_sge ? ((r_acc >> 1) + r_y) : (r_acc >> 1);
    end

    // Load on start, then advance one bit or one root digit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_cnt  <= '0;
                r_x    <= i_req.a;
                r_acc  <= '0;
                if (i_req.op == scr_pkg::ALU_SQRT) begin
                    r_y <= 64'h4000_0000_0000_0000;
                end else begin
                    r_y <= i_req.b;
                end
            end else if (r_busy) begin
                case (r_op)
                    scr_pkg::ALU_MUL: begin
                        if (r_x == '0) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                            r_res  <= r_acc;
                        end else begin
                            if (r_x[0]) begin
                                r_acc <= r_acc + r_y;
                            end
                            r_x <= r_x >> 1;
                            r_y <= r_y << 1;
                        end
                    end
                    scr_pkg::ALU_DIV: begin
                        r_acc <= w_rem_n[63:0];
                        r_x   <= {r_x[62:0], w_dge};
                        r_cnt <= r_cnt + 6'd1;
                        if (r_cnt == 6'd63) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                            r_res  <= {r_x[62:0], w_dge};
                        end
                    end
                    scr_pkg::ALU_SQRT: begin
                        if (w_sge) begin
                            r_x <= r_x - w_t;
                        end
                        r_acc <= w_root_n;
                        r_y   <= r_y >> 2;
                        r_cnt <= r_cnt + 6'd1;
                        if (r_cnt == 6'd31) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                            r_res  <= w_root_n;
                        end
                    end
                    default: begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                        r_res  <= '0;
                    end
                endcase
            end
        end
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

endmodule

>>> sv/sphere_collision_resolver_unit.sv
// Sphere collision resolver: body store, sequencer and write-back.
// Depends on scr_pkg, scr_iter_alu and the assertion macro header.
//
// Use: each input item on the s_axis channel (tuser = operation) writes a
// body, reads a body back, or resolves a collision between two bodies.
// Every item gives exactly one result item on the m_axis channel: the body
// read (tdata), and contact, impulse and saturation flags (tuser).
// Bodies live in one single-port-write memory with one registered read.
// A write with nonzero mass first runs one 64-step divide for the inverse
// mass; a read uses no unit operation; a resolve runs up to 31 operations
// on the shared bit-serial multiply/divide/root unit. One item is worked at
// a time; the next item is taken as soon as the previous result sits in
// the output register, even if the receiver has not taken it yet.
// Reset clears the control state only; a body must be written before it is
// read or resolved. When the receiver stalls, the result holds in the
// output register and the block stops before loading the next one.
`include "sphere_collision_resolver_unit_macros.svh"

module sphere_collision_resolver_unit #(
    parameter int BODY_COUNT    = 64,
    parameter int FRACTION_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // first_body, second_body, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
    // body_mass, body_radius, body_restitution, zero pad
    input  logic [287:0] i_s_axis_tdata,
    // operation
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y, out_vel_z
    output logic [191:0] o_m_axis_tdata,
    // contact, impulse_applied, saturated
    output logic [2:0]   o_m_axis_tuser
);

    localparam int          AW         = (BODY_COUNT > 1) ? $clog2(BODY_COUNT) : 1;
    localparam int          NEAR_LIMIT = ((1 << FRACTION_BITS) + 500) / 1000;
    localparam logic [63:0] Q_ONE      = 64'd1 << FRACTION_BITS;

    // Sequencer groups; a group of three works once per axis
    localparam logic [3:0] G_SQ   = 4'd0;
    localparam logic [3:0] G_SQRT = 4'd1;
    localparam logic [3:0] G_N    = 4'd2;
    localparam logic [3:0] G_RB   = 4'd3;
    localparam logic [3:0] G_RA   = 4'd4;
    localparam logic [3:0] G_SA   = 4'd5;
    localparam logic [3:0] G_SB   = 4'd6;
    localparam logic [3:0] G_PA   = 4'd7;
    localparam logic [3:0] G_PB   = 4'd8;
    localparam logic [3:0] G_DOT  = 4'd9;
    localparam logic [3:0] G_JN   = 4'd10;
    localparam logic [3:0] G_J    = 4'd11;
    localparam logic [3:0] G_IMP  = 4'd12;
    localparam logic [3:0] G_VA   = 4'd13;
    localparam logic [3:0] G_VB   = 4'd14;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_LDA  = 9'b000000010,
        ST_LDB  = 9'b000000100,
        ST_DIFF = 9'b000001000,
        ST_CALC = 9'b000010000,
        ST_WINV = 9'b000100000,
        ST_WRA  = 9'b001000000,
        ST_WRB  = 9'b010000000,
        ST_OUT  = 9'b100000000
    } t_state;

    function automatic logic [63:0] f_mag(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // Clamp to 32-bit signed range; top bit flags a clamp
    function automatic logic [32:0] f_sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (v < -64'sd2147483648) begin
            return {1'b1, 32'h8000_0000};
        end else begin
            return {1'b0, v[31:0]};
        end
    endfunction

    t_state              r_state;
    logic                r_wait;
    logic [1:0]          r_op;
    logic [5:0]          r_ia;
    logic [5:0]          r_ib;
    logic [3:0]          r_grp;
    logic [1:0]          r_idx;
    logic                r_neg;
    scr_pkg::t_body      r_ba;
    scr_pkg::t_body      r_bb;
    scr_pkg::t_body      r_rd_data;
    scr_pkg::t_body      r_mem [BODY_COUNT];
    logic signed [31:0]  r_d [3];
    logic signed [31:0]  r_n [3];
    logic signed [63:0]  r_imp [3];
    logic [63:0]         r_sq;
    logic [63:0]         r_dist;
    logic [63:0]         r_overlap;
    logic [63:0]         r_total;
    logic [63:0]         r_rb;
    logic [63:0]         r_ra;
    logic [63:0]         r_sa;
    logic [63:0]         r_sb;
    logic signed [63:0]  r_dot;
    logic [63:0]         r_vanm;
    logic [63:0]         r_jnum;
    logic [63:0]         r_j;
    logic [191:0]        r_rdout;
    logic                r_contact;
    logic                r_impulse;
    logic                r_sat;
    logic                r_ovalid;
    logic [191:0]        r_odata;
    logic [2:0]          r_ouser;

    scr_pkg::t_alu_req   w_req;
    scr_pkg::t_alu_rsp   w_rsp;
    logic                w_neg;
    logic                w_accept;
    logic                w_a_ok;
    logic                w_b_ok;
    logic                w_out_free;
    logic                w_rd_en;
    logic [AW-1:0]       w_rd_addr;
    logic                w_we;
    logic [AW-1:0]       w_wr_addr;
    logic signed [63:0]  w_full;
    logic signed [63:0]  w_tq;
    logic [63:0]         w_sh;
    logic signed [63:0]  w_overlap;
    logic signed [63:0]  w_dot_n;
    logic [63:0]         w_van_mag;
    logic [63:0]         w_isum;
    logic [15:0]         w_e;
    logic [63:0]         w_one_e;
    logic signed [63:0]  w_dv;
    logic [32:0]         w_sat_a;
    logic [32:0]         w_sat_b;
    logic [32:0]         w_sdiff [3];

    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_a_ok     = 32'(i_s_axis_tdata[5:0]) < BODY_COUNT;
    assign w_b_ok     = 32'(i_s_axis_tdata[11:6]) < BODY_COUNT;
    assign w_out_free = !r_ovalid || i_m_axis_tready;

    // Signed results of the shared unit, full and scaled down by one Q unit
    always_comb begin
        w_sh      = w_rsp.result >> FRACTION_BITS;
        w_full    = r_neg ? -$signed(w_rsp.result) : $signed(w_rsp.result);
        w_tq      = r_neg ? -$signed(w_sh) : $signed(w_sh);
        w_overlap = $signed(64'(r_ba.radius) + 64'(r_bb.radius) - r_dist);
        w_dot_n   = r_dot + w_full;
        w_van_mag = f_mag(w_dot_n) >> FRACTION_BITS;
        w_isum    = 64'(r_ba.inv) + 64'(r_bb.inv);
        w_e       = 16'((17'(r_ba.rest) + 17'(r_bb.rest)) >> 1);
        w_one_e   = Q_ONE + 64'({w_e, 24'd0} >> (40 - FRACTION_BITS));
        w_dv      = 64'($signed(r_ba.vel[r_idx])) - 64'($signed(r_bb.vel[r_idx]));
        w_sat_a   = f_sat32(64'($signed(r_ba.pos[r_idx])) + w_tq);
        w_sat_b   = f_sat32(64'($signed(r_bb.pos[r_idx])) - w_tq);
        for (int i = 0; i < 3; i++) begin
            w_sdiff[i] = f_sat32(64'($signed(r_ba.pos[i])) - 64'($signed(r_bb.pos[i])));
        end
        if (r_grp == G_VA) begin
            w_sat_a = f_sat32(64'($signed(r_ba.vel[r_idx])) + w_tq);
        end
        if (r_grp == G_VB) begin
            w_sat_b = f_sat32(64'($signed(r_bb.vel[r_idx])) - w_tq);
        end
    end

    // Pick the operation and operands for the current sequencer step
    always_comb begin
        w_req.op = scr_pkg::ALU_MUL;
        w_req.a  = '0;
        w_req.b  = '0;
        w_neg    = 1'b0;
        if (r_state == ST_WINV) begin
            w_req.op = scr_pkg::ALU_DIV;
            w_req.a  = 64'd1 << (2 * FRACTION_BITS);
            w_req.b  = 64'(r_ba.mass);
        end else begin
            case (r_grp)
                G_SQ: begin
                    w_req.a = f_mag(64'(r_d[r_idx]));
                    w_req.b = f_mag(64'(r_d[r_idx]));
                end
                G_SQRT: begin
                    w_req.op = scr_pkg::ALU_SQRT;
                    w_req.a  = r_sq;
                end
                G_N: begin
                    w_req.op = scr_pkg::ALU_DIV;
                    w_req.a  = f_mag(64'(r_d[r_idx])) << FRACTION_BITS;
                    w_req.b  = r_dist;
                    w_neg    = r_d[r_idx][31];
                end
                G_RB: begin
                    w_req.op = scr_pkg::ALU_DIV;
                    w_req.a  = 64'(r_bb.mass) << FRACTION_BITS;
                    w_req.b  = r_total;
                end
                G_RA: begin
                    w_req.op = scr_pkg::ALU_DIV;
                    w_req.a  = 64'(r_ba.mass) << FRACTION_BITS;
                    w_req.b  = r_total;
                end
                G_SA: begin
                    w_req.a = r_overlap;
                    w_req.b = r_rb;
                end
                G_SB: begin
                    w_req.a = r_overlap;
                    w_req.b = r_ra;
                end
                G_PA: begin
                    w_req.a = f_mag(64'(r_n[r_idx]));
                    w_req.b = r_sa;
                    w_neg   = r_n[r_idx][31];
                end
                G_PB: begin
                    w_req.a = f_mag(64'(r_n[r_idx]));
                    w_req.b = r_sb;
                    w_neg   = r_n[r_idx][31];
                end
                G_DOT: begin
                    w_req.a = f_mag(w_dv);
                    w_req.b = f_mag(64'(r_n[r_idx]));
                    w_neg   = w_dv[63] ^ r_n[r_idx][31];
                end
                G_JN: begin
                    w_req.a = r_vanm;
                    w_req.b = w_one_e;
                end
                G_J: begin
                    w_req.op = scr_pkg::ALU_DIV;
                    w_req.a  = r_jnum << FRACTION_BITS;
                    w_req.b  = w_isum;
                end
                G_IMP: begin
                    w_req.a = f_mag(64'(r_n[r_idx]));
                    w_req.b = r_j;
                    w_neg   = r_n[r_idx][31];
                end
                G_VA: begin
                    w_req.a = f_mag(r_imp[r_idx]);
                    w_req.b = 64'(r_ba.inv);
                    w_neg   = r_imp[r_idx][63];
                end
                G_VB: begin
                    w_req.a = f_mag(r_imp[r_idx]);
                    w_req.b = 64'(r_bb.inv);
                    w_neg   = r_imp[r_idx][63];
                end
                default: begin
                    w_req.a = '0;
                end
            endcase
        end
        w_req.start = ((r_state == ST_WINV) || (r_state == ST_CALC)) && !r_wait;
    end

    scr_iter_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Body store: one registered read, one write
    assign w_rd_en   = w_accept || (r_state == ST_LDA);
    assign w_rd_addr = (r_state == ST_LDA) ? AW'(r_ib) : AW'(i_s_axis_tdata[5:0]);
    assign w_we      = (r_state == ST_WRA) || (r_state == ST_WRB);
    assign w_wr_addr = (r_state == ST_WRB) ? AW'(r_ib) : AW'(r_ia);

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
        if (w_we) begin
            r_mem[w_wr_addr] <= (r_state == ST_WRB) ? r_bb : r_ba;
        end
    end

    // Sequencer: load, compute through the shared unit, write back, deliver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_wait   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (w_req.start) begin
                r_wait <= 1'b1;
                r_neg  <= w_neg;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_op          <= i_s_axis_tuser;
                        r_ia          <= i_s_axis_tdata[5:0];
                        r_ib          <= i_s_axis_tdata[11:6];
                        r_ba.pos[0]   <= i_s_axis_tdata[43:12];
                        r_ba.pos[1]   <= i_s_axis_tdata[75:44];
                        r_ba.pos[2]   <= i_s_axis_tdata[107:76];
                        r_ba.vel[0]   <= i_s_axis_tdata[139:108];
                        r_ba.vel[1]   <= i_s_axis_tdata[171:140];
                        r_ba.vel[2]   <= i_s_axis_tdata[203:172];
                        r_ba.mass     <= i_s_axis_tdata[234:204];
                        r_ba.inv      <= '0;
                        r_ba.radius   <= i_s_axis_tdata[265:235];
                        r_ba.rest     <= i_s_axis_tdata[281:266];
                        r_rdout       <= '0;
                        r_contact     <= 1'b0;
                        r_impulse     <= 1'b0;
                        r_sat         <= 1'b0;
                        r_wait        <= 1'b0;
                        if (i_s_axis_tuser == scr_pkg::OP_WRITE && w_a_ok) begin
                            r_state <= (i_s_axis_tdata[234:204] == '0) ? ST_WRA : ST_WINV;
                        end else if (i_s_axis_tuser == scr_pkg::OP_READ && w_a_ok) begin
                            r_state <= ST_LDA;
                        end else if (i_s_axis_tuser == scr_pkg::OP_RESOLVE && w_a_ok
                                     && w_b_ok
                                     && i_s_axis_tdata[5:0] != i_s_axis_tdata[11:6]) begin
                            r_state <= ST_LDA;
                        end else begin
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_WINV: begin
                    if (w_rsp.done) begin
                        r_wait <= 1'b0;
                        if (w_rsp.result > 64'h7FFF_FFFF) begin
                            r_ba.inv <= 31'h7FFF_FFFF;
                            r_sat    <= 1'b1;
                        end else begin
                            r_ba.inv <= w_rsp.result[30:0];
                        end
                        r_state <= ST_WRA;
                    end
                end
                ST_LDA: begin
                    r_ba <= r_rd_data;
                    if (r_op == scr_pkg::OP_READ) begin
                        r_rdout <= {r_rd_data.vel, r_rd_data.pos};
                        r_state <= ST_OUT;
                    end else begin
                        r_state <= ST_LDB;
                    end
                end
                ST_LDB: begin
                    r_bb    <= r_rd_data;
                    r_state <= ST_DIFF;
                end
                ST_DIFF: begin
                    for (int i = 0; i < 3; i++) begin
                        r_d[i] <= $signed(w_sdiff[i][31:0]);
                    end
                    if (w_sdiff[0][32] || w_sdiff[1][32] || w_sdiff[2][32]) begin
                        r_sat <= 1'b1;
                    end
                    r_sq    <= '0;
                    r_dot   <= '0;
                    r_grp   <= G_SQ;
                    r_idx   <= '0;
                    r_wait  <= 1'b0;
                    r_state <= ST_CALC;
                end
                ST_CALC: begin
                    if (w_rsp.done) begin
                        r_wait <= 1'b0;
                        r_idx  <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                        case (r_grp)
                            G_SQ: begin
                                r_sq <= r_sq + w_rsp.result;
                                if (r_idx == 2'd2) begin
                                    r_grp <= G_SQRT;
                                end
                            end
                            G_SQRT: begin
                                r_idx <= '0;
                                r_grp <= G_N;
                                if (w_rsp.result < 64'(NEAR_LIMIT)) begin
                                    r_d[0] <= 32'(Q_ONE);
                                    r_d[1] <= '0;
                                    r_d[2] <= '0;
                                    r_dist <= Q_ONE;
                                end else begin
                                    r_dist <= w_rsp.result;
                                end
                            end
                            G_N: begin
                                r_n[r_idx] <= w_full[31:0];
                                if (r_idx == 2'd2) begin
                                    r_overlap <= 64'(w_overlap);
                                    r_total   <= 64'(r_ba.mass) + 64'(r_bb.mass);
                                    if (w_overlap < 0) begin
                                        r_state <= ST_OUT;
                                    end else begin
                                        r_contact <= 1'b1;
                                        if (r_ba.mass == '0 && r_bb.mass == '0) begin
                                            r_grp <= G_DOT;
                                        end else begin
                                            r_grp <= G_RB;
                                        end
                                    end
                                end
                            end
                            G_RB: begin
                                r_idx <= '0;
                                r_rb  <= w_rsp.result;
                                r_grp <= G_RA;
                            end
                            G_RA: begin
                                r_idx <= '0;
                                r_ra  <= w_rsp.result;
                                r_grp <= G_SA;
                            end
                            G_SA: begin
                                r_idx <= '0;
                                r_sa  <= w_sh;
                                r_grp <= G_SB;
                            end
                            G_SB: begin
                                r_idx <= '0;
                                r_sb  <= w_sh;
                                r_grp <= G_PA;
                            end
                            G_PA: begin
                                r_ba.pos[r_idx] <= w_sat_a[31:0];
                                if (w_sat_a[32]) begin
                                    r_sat <= 1'b1;
                                end
                                if (r_idx == 2'd2) begin
                                    r_grp <= G_PB;
                                end
                            end
                            G_PB: begin
                                r_bb.pos[r_idx] <= w_sat_b[31:0];
                                if (w_sat_b[32]) begin
                                    r_sat <= 1'b1;
                                end
                                if (r_idx == 2'd2) begin
                                    r_grp <= G_DOT;
                                end
                            end
                            G_DOT: begin
                                r_dot <= w_dot_n;
                                if (r_idx == 2'd2) begin
                                    r_vanm <= w_van_mag;
                                    if ((!w_dot_n[63] && w_van_mag != '0) || w_isum == '0) begin
                                        r_state <= ST_WRA;
                                    end else begin
                                        r_grp <= G_JN;
                                    end
                                end
                            end
                            G_JN: begin
                                r_idx  <= '0;
                                r_jnum <= w_sh;
                                r_grp  <= G_J;
                            end
                            G_J: begin
                                r_idx <= '0;
                                r_grp <= G_IMP;
                                if (w_rsp.result > 64'h7FFF_FFFF) begin
                                    r_j   <= 64'h7FFF_FFFF;
                                    r_sat <= 1'b1;
                                end else begin
                                    r_j <= w_rsp.result;
                                end
                            end
                            G_IMP: begin
                                r_imp[r_idx] <= w_tq;
                                if (r_idx == 2'd2) begin
                                    r_grp <= G_VA;
                                end
                            end
                            G_VA: begin
                                r_ba.vel[r_idx] <= w_sat_a[31:0];
                                if (w_sat_a[32]) begin
                                    r_sat <= 1'b1;
                                end
                                if (r_idx == 2'd2) begin
                                    r_grp <= G_VB;
                                end
                            end
                            G_VB: begin
                                r_bb.vel[r_idx] <= w_sat_b[31:0];
                                if (w_sat_b[32]) begin
                                    r_sat <= 1'b1;
                                end
                                if (r_idx == 2'd2) begin
                                    r_impulse <= 1'b1;
                                    r_state   <= ST_WRA;
                                end
                            end
                            default: begin
                                r_state <= ST_OUT;
                            end
                        endcase
                    end
                end
                ST_WRA: begin
                    r_state <= (r_op == scr_pkg::OP_RESOLVE) ? ST_WRB : ST_OUT;
                end
                ST_WRB: begin
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= r_rdout;
                        r_ouser  <= {r_sat, r_impulse, r_contact};
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;

    `SCR_ASSERT_IMPL(a_alu_free, w_req.start, !w_rsp.busy && !w_rsp.done, "unit started while busy")
    `SCR_ASSERT_IMPL(a_done_waits, w_rsp.done, r_wait, "unit result with no request pending")
    `SCR_ASSERT_IMPL(a_impulse_contact, o_m_axis_tvalid && o_m_axis_tuser[1], o_m_axis_tuser[0], "impulse without contact")
    `SCR_ASSERT_NEXT(a_busy_after_accept, w_accept, !o_s_axis_tready, "item taken while busy")

endmodule
